[rtl/core/tape_machine_instruction_execute_macros.svh]
// assertion macros for the tape machine core
// no dependencies; included by modules that carry assertions
`ifndef TAPE_MACHINE_INSTRUCTION_EXECUTE_MACROS_SVH
`define TAPE_MACHINE_INSTRUCTION_EXECUTE_MACROS_SVH

`ifndef ASSERT_OFF
`define TME_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define TME_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);
`else
`define TME_ASSERT(lbl, clk, rst_n, prop, msg)
`define TME_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)
`endif

`endif

[rtl/core/tme_pkg.sv]
// shared types and constants of the tape machine core
// no dependencies
package tme_pkg;

    localparam int TME_TAPE_DEPTH   = 32768;
    localparam int CFG_LEN_W        = 16;
    localparam int CFG_LEN_RESET    = 32768;
    localparam logic [7:0] CELL_MAX = 8'd255;

    typedef enum logic [2:0] {
        CMD_RIGHT = 3'd0,
        CMD_LEFT  = 3'd1,
        CMD_INC   = 3'd2,
        CMD_DEC   = 3'd3,
        CMD_OUT   = 3'd4,
        CMD_IN    = 3'd5,
        CMD_OPEN  = 3'd6,
        CMD_CLOSE = 3'd7
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_PAST_END   = 3'd1,
        ST_BELOW_ZERO = 3'd2,
        ST_OVERFLOW   = 3'd3,
        ST_UNDERFLOW  = 3'd4
    } status_t;

    typedef struct packed {
        cmd_t       cmd;
        logic [7:0] in_byte;
        logic       in_eof;
    } item_t;

    typedef struct packed {
        status_t    status;
        logic       out_valid;
        logic [7:0] out_byte;
        logic       take_jump;
    } res_t;

endpackage

[rtl/core/tme_core.sv]
// tape memory, data pointer and two-stage read-modify-write execution
// depends on tme_pkg and the macros header
`include "tape_machine_instruction_execute_macros.svh"

module tme_core
    import tme_pkg::*;
#(
    parameter int TAPE_DEPTH = TME_TAPE_DEPTH
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [((($clog2(TAPE_DEPTH) + 1) > CFG_LEN_W) ?
                   ($clog2(TAPE_DEPTH) + 1) : CFG_LEN_W) - 1:0] eff_len,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  item_t                         s_item,
    output logic                          m_valid,
    input  logic                          m_ready,
    output res_t                          m_res
);

    localparam int PTR_W  = $clog2(TAPE_DEPTH);
    localparam int FILL_W = PTR_W + 1;
    localparam int CW     = (FILL_W > CFG_LEN_W) ? FILL_W : CFG_LEN_W;

    typedef struct packed {
        cmd_t             cmd;
        logic [7:0]       in_byte;
        logic             in_eof;
        logic [PTR_W-1:0] addr;
        status_t          mstat;
        logic             hit;
        logic [7:0]       fwd;
        logic             fresh;
    } stage_t;

    logic [7:0]       mem [TAPE_DEPTH];
    logic [7:0]       rdata_reg;
    logic             s1_valid_reg;
    stage_t           s1_reg;
    stage_t           s1_next;
    logic [PTR_W-1:0] ptr_reg;
    logic [PTR_W-1:0] ptr_next;
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic             m_valid_reg;
    res_t             m_res_reg;

    logic             s1_go;
    logic             s_accept;
    logic [7:0]       cur_cell;
    res_t             res;
    logic             wr;
    logic             wr_en;
    logic [7:0]       wr_data;
    status_t          mstat;
    logic [CW-1:0]    ptr_ext;

    assign s1_go    = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready  = !s1_valid_reg || s1_go;
    assign s_accept = s_valid && s_ready;

    // cells at or above the fill count were never written and read as zero
    assign cur_cell = s1_reg.hit ? s1_reg.fwd : (s1_reg.fresh ? 8'd0 : rdata_reg);

    always_comb begin
        res     = '{status: ST_OK, out_valid: 1'b0, out_byte: 8'd0, take_jump: 1'b0};
        wr      = 1'b0;
        wr_data = 8'd0;
        unique case (s1_reg.cmd)
            CMD_RIGHT: begin
                res.status = s1_reg.mstat;
                // leaving a fresh cell: store its zero so the fill count can advance
                wr = (s1_reg.mstat == ST_OK) && s1_reg.fresh;
            end
            CMD_LEFT: begin
                res.status = s1_reg.mstat;
            end
            CMD_INC: begin
                if (cur_cell == CELL_MAX) begin
                    res.status = ST_OVERFLOW;
                end else begin
                    wr      = 1'b1;
                    wr_data = cur_cell + 8'd1;
                end
            end
            CMD_DEC: begin
                if (cur_cell == 8'd0) begin
                    res.status = ST_UNDERFLOW;
                end else begin
                    wr      = 1'b1;
                    wr_data = cur_cell - 8'd1;
                end
            end
            CMD_OUT: begin
                res.out_valid = 1'b1;
                res.out_byte  = cur_cell;
            end
            CMD_IN: begin
                wr      = 1'b1;
                wr_data = s1_reg.in_eof ? 8'd0 : s1_reg.in_byte;
            end
            CMD_OPEN: begin
                res.take_jump = (cur_cell == 8'd0);
            end
            CMD_CLOSE: begin
                res.take_jump = (cur_cell != 8'd0);
            end
            default: begin
                res.status = ST_OK;
            end
        endcase
    end

    assign wr_en     = s1_go && wr;
    assign fill_next = (wr_en && s1_reg.fresh) ? fill_reg + FILL_W'(1) : fill_reg;

    // pointer checks happen at accept, the cell work when the word leaves the stage register
    assign ptr_ext = CW'(ptr_reg);

    always_comb begin
        mstat    = ST_OK;
        ptr_next = ptr_reg;
        priority case (s_item.cmd)
            CMD_RIGHT: begin
                if (ptr_ext + CW'(1) >= eff_len) begin
                    mstat = ST_PAST_END;
                end else begin
                    ptr_next = ptr_reg + PTR_W'(1);
                end
            end
            CMD_LEFT: begin
                priority if (ptr_reg == '0) begin
                    mstat = ST_BELOW_ZERO;
                end else if (ptr_ext - CW'(1) >= eff_len) begin
                    mstat = ST_PAST_END;
                end else begin
                    ptr_next = ptr_reg - PTR_W'(1);
                end
            end
            default: begin
                ptr_next = ptr_reg;
            end
        endcase
    end

    always_comb begin
        s1_next.cmd     = s_item.cmd;
        s1_next.in_byte = s_item.in_byte;
        s1_next.in_eof  = s_item.in_eof;
        s1_next.addr    = ptr_reg;
        s1_next.mstat   = mstat;
        // write retiring on the same edge as this read: memory would give old data
        s1_next.hit     = wr_en && (s1_reg.addr == ptr_reg);
        s1_next.fwd     = wr_data;
        s1_next.fresh   = (FILL_W'(ptr_reg) == fill_next);
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[s1_reg.addr] <= wr_data;
        end
        if (s_accept) begin
            rdata_reg <= mem[ptr_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            ptr_reg      <= '0;
            fill_reg     <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            fill_reg <= fill_next;
            if (s_accept) begin
                ptr_reg <= ptr_next;
            end
            if (s_ready) begin
                s1_valid_reg <= s_valid;
            end
            if (s1_go) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_reg <= s1_next;
        end
        if (s1_go) begin
            m_res_reg <= res;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_res   = m_res_reg;

    `TME_ASSERT(a_addr_within_fill, aclk, aresetn,
                !s1_valid_reg || (FILL_W'(s1_reg.addr) <= fill_reg),
                "stage address beyond fill count")
    `TME_ASSERT(a_hit_not_fresh, aclk, aresetn,
                !(s1_valid_reg && s1_reg.hit && s1_reg.fresh),
                "forwarded cell marked fresh")
    `TME_ASSERT(a_fill_step, aclk, aresetn,
                (fill_reg == $past(fill_reg)) || (fill_reg == $past(fill_reg) + FILL_W'(1)),
                "fill count jumped")
    `TME_ASSERT_NEXT(a_result_follows, aclk, aresetn, s1_go, m_valid_reg,
                     "retired word not presented")

endmodule

[rtl/core/tape_machine_instruction_execute.sv]
// top level of the tape machine core: stream ports, register port
// depends on tme_pkg and tme_core
// Executes one tape-machine command per accepted word and returns exactly one result word
// for it. Sustained rate is one word per clock: the tape memory is read at accept and
// written back from the stage register, a same-cell write in flight is forwarded, so
// back-to-back commands on one cell never stall. A result reaches the m_ side through
// the output register; only a stalled m_tready slows the input. The tape needs no
// clearing pass after reset: a fill count marks how far the pointer has ever gone and
// cells beyond it read as zero, so words are taken from the first cycle out of reset.
// tape_length lies at address 0 and should be written only while idle.
module tape_machine_instruction_execute
    import tme_pkg::*;
#(
    parameter int TAPE_DEPTH = TME_TAPE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // in_byte[7:0]
    input  logic [3:0]  s_tuser,   // cmd[2:0], in_eof[3]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // out_byte[7:0], take_jump[8], zero pad
    output logic [3:0]  m_tuser,   // status[2:0], out_valid[3]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int PTR_W  = $clog2(TAPE_DEPTH);
    localparam int FILL_W = PTR_W + 1;
    localparam int CW     = (FILL_W > CFG_LEN_W) ? FILL_W : CFG_LEN_W;
    localparam int LEN_RESET = (CFG_LEN_RESET > TAPE_DEPTH) ? TAPE_DEPTH : CFG_LEN_RESET;
    localparam logic [1:0] ADDR_TAPE_LENGTH = 2'd0;

    logic [CFG_LEN_W-1:0] tape_length_reg;
    logic [CW-1:0]        eff_len_reg;
    logic [CW-1:0]        eff_len_next;
    logic [CW-1:0]        wr_len;
    logic                 cfg_wr;
    item_t                item;
    res_t                 res;

    // single register: writes land on tape_length at any address
    assign cfg_wr = psel && penable && pwrite && pready;
    assign wr_len = CW'(pwdata[CFG_LEN_W-1:0]);

    always_comb begin
        priority if (wr_len == '0) begin
            eff_len_next = CW'(1);
        end else if (wr_len > CW'(TAPE_DEPTH)) begin
            eff_len_next = CW'(TAPE_DEPTH);
        end else begin
            eff_len_next = wr_len;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tape_length_reg <= CFG_LEN_W'(CFG_LEN_RESET);
            eff_len_reg     <= CW'(LEN_RESET);
        end else if (cfg_wr) begin
            tape_length_reg <= pwdata[CFG_LEN_W-1:0];
            eff_len_reg     <= eff_len_next;
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_TAPE_LENGTH) ?
                    {{(32 - CFG_LEN_W){1'b0}}, tape_length_reg} : '0;

    assign item.cmd     = cmd_t'(s_tuser[2:0]);
    assign item.in_eof  = s_tuser[3];
    assign item.in_byte = s_tdata;

    tme_core #(
        .TAPE_DEPTH (TAPE_DEPTH)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .eff_len (eff_len_reg),
        .s_valid (s_tvalid),
        .s_ready (s_tready),
        .s_item  (item),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .m_res   (res)
    );

    assign m_tdata = {7'd0, res.take_jump, res.out_byte};
    assign m_tuser = {res.out_valid, res.status};

endmodule

[sim/tme_result_check.sv]
// result checker for the tape machine core: predicts every result word and compares
// depends on tme_pkg; watches the stream ports and the register port of the core
`timescale 1ns / 1ps
module tme_result_check
    import tme_pkg::*;
#(
    parameter logic [1:0] LEN_ADDR = 2'd0
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // in_byte[7:0]
    input  logic [3:0]  s_tuser,   // cmd[2:0], in_eof[3]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,   // out_byte[7:0], take_jump[8], zero pad
    input  logic [3:0]  m_tuser,   // status[2:0], out_valid[3]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output int          mismatches,
    output int          outstanding,
    output int          results_seen,
    output logic [4:0]  status_mask
);

    localparam int REPORT_LIMIT = 10;

    logic [7:0]  tape_q [TME_TAPE_DEPTH];
    int          data_ptr;
    logic [15:0] tape_length_q;
    res_t        expected_q[$];
    int          fail_count;
    int          checked;

    initial begin
        mismatches   = 0;
        outstanding  = 0;
        results_seen = 0;
        status_mask  = '0;
        fail_count   = 0;
        checked      = 0;
    end

    // runs one command against the shadow tape and returns the result it must give
    function automatic res_t execute_word(input cmd_t op, input logic [7:0] din,
                                          input logic eof);
        res_t       r;
        int         span;
        logic [7:0] cur;
        span = (tape_length_q == 16'd0) ? 1 : int'(tape_length_q);
        if (span > TME_TAPE_DEPTH)
            span = TME_TAPE_DEPTH;
        cur = tape_q[data_ptr];
        r = '0;
        r.status = ST_OK;
        case (op)
            CMD_RIGHT: begin
                if (data_ptr + 1 >= span)
                    r.status = ST_PAST_END;
                else
                    data_ptr = data_ptr + 1;
            end
            CMD_LEFT: begin
                if (data_ptr == 0)
                    r.status = ST_BELOW_ZERO;
                else if (data_ptr - 1 >= span)
                    r.status = ST_PAST_END;
                else
                    data_ptr = data_ptr - 1;
            end
            CMD_INC: begin
                if (cur == CELL_MAX)
                    r.status = ST_OVERFLOW;
                else
                    tape_q[data_ptr] = cur + 8'd1;
            end
            CMD_DEC: begin
                if (cur == 8'd0)
                    r.status = ST_UNDERFLOW;
                else
                    tape_q[data_ptr] = cur - 8'd1;
            end
            CMD_OUT: begin
                r.out_valid = 1'b1;
                r.out_byte  = cur;
            end
            CMD_IN: begin
                tape_q[data_ptr] = eof ? 8'd0 : din;
            end
            CMD_OPEN: begin
                r.take_jump = (cur == 8'd0);
            end
            default: begin
                r.take_jump = (cur != 8'd0);
            end
        endcase
        return r;
    endfunction

    always @(posedge aclk) begin
        res_t got;
        res_t want;
        if (!aresetn) begin
            foreach (tape_q[i])
                tape_q[i] = 8'd0;
            data_ptr      = 0;
            tape_length_q = 16'(CFG_LEN_RESET);
            expected_q.delete();
            outstanding  <= 0;
        end else begin
            if (psel && penable && pwrite && pready && paddr == LEN_ADDR)
                tape_length_q = pwdata[15:0];

            // compare before pushing so a word accepted this edge is never matched here
            if (m_tvalid && m_tready) begin
                got.status    = status_t'(m_tuser[2:0]);
                got.out_valid = m_tuser[3];
                got.out_byte  = m_tdata[7:0];
                got.take_jump = m_tdata[8];
                checked++;
                if (expected_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("[%0t] result word %0d with nothing expected: status %0d",
                                 $realtime, checked, got.status);
                end else begin
                    want = expected_q.pop_front();
                    if (got !== want) begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT) begin
                            $display("[%0t] result word %0d: expected status %0d valid %0b %s",
                                     $realtime, checked, want.status, want.out_valid, "");
                            $display("    expected byte %02h jump %0b", want.out_byte,
                                     want.take_jump);
                            $display("    got status %0d valid %0b byte %02h jump %0b",
                                     got.status, got.out_valid, got.out_byte, got.take_jump);
                        end
                    end
                end
            end

            if (s_tvalid && s_tready) begin
                want = execute_word(cmd_t'(s_tuser[2:0]), s_tdata, s_tuser[3]);
                expected_q.push_back(want);
                status_mask[int'(want.status)] <= 1'b1;
            end

            outstanding  <= expected_q.size();
            results_seen <= checked;
            mismatches   <= fail_count;
        end
    end

endmodule

[sim/tb_top.sv]
// testbench top for the tape machine core: clock, reset, stimulus and verdict
// depends on tme_pkg, tape_machine_instruction_execute and tme_result_check
`timescale 1ns / 1ps
module tb_top
    import tme_pkg::*;
();

    localparam logic [1:0] ADDR_TAPE_LENGTH = 2'd0;
    localparam int         WATCHDOG_LIMIT   = 2000;
    localparam int         HOLD_AFTER       = 250;
    localparam int         HOLD_CYCLES      = 120;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;    // in_byte[7:0]
    logic [3:0]  s_tuser  = '0;    // cmd[2:0], in_eof[3]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;          // out_byte[7:0], take_jump[8], zero pad
    logic [3:0]  m_tuser;          // status[2:0], out_valid[3]
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [1:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    int          mismatches;
    int          outstanding;
    int          results_seen;
    logic [4:0]  status_mask;
    int          words_sent   = 0;
    int          length_count = 0;
    int          burst_left   = 0;
    int          quiet_cycles = 0;
    bit          hold_done    = 1'b0;

    tape_machine_instruction_execute i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    tme_result_check #(
        .LEN_ADDR (ADDR_TAPE_LENGTH)
    ) i_result_check (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .mismatches   (mismatches),
        .outstanding  (outstanding),
        .results_seen (results_seen),
        .status_mask  (status_mask)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // ends the run when neither channel moves a word for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // receiver: ready, random or 3-of-4 stretches, plus one long hold
    initial begin : rx_pattern
        int mode;
        int stretch;
        int phase;
        phase = 0;
        wait (aresetn);
        forever begin
            mode    = $urandom_range(0, 2);
            stretch = $urandom_range(8, 60);
            repeat (stretch) begin
                @(posedge aclk);
                phase++;
                if (!hold_done && results_seen >= HOLD_AFTER) begin
                    hold_done = 1'b1;
                    m_tready <= 1'b0;
                    repeat (HOLD_CYCLES) @(posedge aclk);
                end else if (mode == 0) begin
                    m_tready <= 1'b1;
                end else if (mode == 1) begin
                    m_tready <= 1'($urandom_range(0, 1));
                end else begin
                    m_tready <= (phase % 4 != 0);
                end
            end
        end
    end

    // presents one word and returns at the edge where it is taken, valid left high
    task automatic send_word(input cmd_t op, input logic [7:0] b, input logic eof);
        bit ready_seen;
        s_tvalid <= 1'b1;
        s_tuser  <= {eof, op};
        s_tdata  <= b;
        do begin
            @(negedge aclk);
            ready_seen = s_tready;
            @(posedge aclk);
        end while (!ready_seen);
        words_sent++;
    endtask

    // send inside bursts with random gaps between them
    task automatic issue(input cmd_t op, input logic [7:0] b, input logic eof);
        int gap;
        send_word(op, b, eof);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(40, 90)
                                                    : $urandom_range(1, 16);
            gap = $urandom_range(0, 4) == 0 ? $urandom_range(10, 25) : $urandom_range(1, 5);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        repeat (2) @(posedge aclk);
        do @(negedge aclk); while (outstanding != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_tape_length(input logic [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_TAPE_LENGTH;
        pwdata  <= {16'h0000, value};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        length_count++;
    endtask

    function automatic cmd_t pick_cmd();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 18)      return CMD_RIGHT;
        else if (roll < 32) return CMD_LEFT;
        else if (roll < 50) return CMD_INC;
        else if (roll < 64) return CMD_DEC;
        else if (roll < 74) return CMD_OUT;
        else if (roll < 84) return CMD_IN;
        else if (roll < 92) return CMD_OPEN;
        else                return CMD_CLOSE;
    endfunction

    // bytes near the cell limits are favored so overflow and underflow come up
    function automatic logic [7:0] pick_byte();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 20)      return 8'hFF;
        else if (roll < 30) return 8'hFE;
        else if (roll < 42) return 8'h00;
        else if (roll < 50) return 8'h01;
        else                return 8'($urandom_range(0, 255));
    endfunction

    task automatic run_random(input int count);
        int         n;
        int         k;
        logic [7:0] b;
        n = 0;
        while (n < count) begin
            if (n >= count / 2 && n < count / 2 + 1)
                drain();
            if ($urandom_range(0, 99) < 8) begin
                // countdown loop: load, then decrement and test until the cell is zero
                b = 8'($urandom_range(1, 5));
                issue(CMD_IN, b, 1'b0);
                issue(CMD_OPEN, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                for (k = 0; k < int'(b); k++) begin
                    issue(CMD_DEC, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                    issue(CMD_CLOSE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                end
                issue(CMD_DEC, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                n += 3 + 2 * int'(b);
            end else begin
                issue(pick_cmd(), pick_byte(), $urandom_range(0, 9) == 0);
                n++;
            end
        end
        drain();
    endtask

    task automatic rewind_pointer();
        repeat (40) issue(CMD_LEFT, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        drain();
    endtask

    initial begin : stimulus
        wait (aresetn);
        @(posedge aclk);

        // cell limits, brackets, input and end of input at the default length
        send_word(CMD_LEFT, 8'h00, 1'b0);
        send_word(CMD_DEC, 8'hFF, 1'b1);
        send_word(CMD_OUT, 8'h00, 1'b0);
        send_word(CMD_OPEN, 8'h00, 1'b0);
        send_word(CMD_CLOSE, 8'h00, 1'b0);
        send_word(CMD_IN, 8'hFF, 1'b0);
        send_word(CMD_OUT, 8'h00, 1'b0);
        send_word(CMD_INC, 8'h00, 1'b0);
        send_word(CMD_CLOSE, 8'h00, 1'b0);
        send_word(CMD_OPEN, 8'h00, 1'b0);
        send_word(CMD_DEC, 8'h00, 1'b0);
        send_word(CMD_IN, 8'hA5, 1'b1);
        send_word(CMD_OUT, 8'h00, 1'b0);
        send_word(CMD_INC, 8'h00, 1'b0);
        send_word(CMD_RIGHT, 8'h00, 1'b0);
        send_word(CMD_IN, 8'h5A, 1'b0);
        send_word(CMD_LEFT, 8'h00, 1'b0);
        send_word(CMD_OUT, 8'h00, 1'b0);
        drain();

        // one-cell tape, then zero which clamps to one
        write_tape_length(16'd1);
        send_word(CMD_RIGHT, 8'h00, 1'b0);
        send_word(CMD_LEFT, 8'h00, 1'b0);
        drain();
        write_tape_length(16'd0);
        send_word(CMD_RIGHT, 8'h00, 1'b0);
        drain();

        // pointer left beyond a shortened tape: moves fail, cell commands still work
        write_tape_length(16'd8);
        repeat (6) send_word(CMD_RIGHT, 8'h00, 1'b0);
        drain();
        write_tape_length(16'd3);
        send_word(CMD_RIGHT, 8'h00, 1'b0);
        send_word(CMD_LEFT, 8'h00, 1'b0);
        send_word(CMD_INC, 8'h00, 1'b0);
        send_word(CMD_OUT, 8'h00, 1'b0);
        drain();
        write_tape_length(16'd7);
        send_word(CMD_LEFT, 8'h00, 1'b0);
        drain();

        write_tape_length(16'(CFG_LEN_RESET));
        rewind_pointer();
        run_random(90);
        rewind_pointer();
        write_tape_length(16'd16);
        run_random(90);
        write_tape_length(16'd2);
        run_random(70);
        write_tape_length(16'hFFFF);
        run_random(90);
        rewind_pointer();
        write_tape_length(16'd5);
        run_random(80);
        write_tape_length(16'($urandom_range(1, 40)));
        run_random(80);

        s_tvalid <= 1'b0;
        repeat (2) @(posedge aclk);
        do @(negedge aclk); while (outstanding != 0);
        repeat (10) @(posedge aclk);

        $display("%0d command words sent, %0d result words checked, %0d tape length writes",
                 words_sent, results_seen, length_count);
        $display("status codes produced (underflow..ok): %b, long receiver hold: %0d",
                 status_mask, hold_done);
        if (mismatches == 0 && outstanding == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
